### rtl/imu_sfp_pkg.sv
// Shared types and constants for the IMU serial frame parser.
// No dependencies; imported by every module of the block.
package imu_sfp_pkg;

    localparam int unsigned StoredLen = 10;
    localparam int unsigned CountW    = 4;

    localparam logic [7:0] HDR_BYTE   = 8'h55;
    localparam logic [7:0] TYPE_ACCEL = 8'h51;
    localparam logic [7:0] TYPE_MAG   = 8'h54;

    // floor(w / 100) == (w * 83887) >> 23 for every 16-bit w
    localparam logic [16:0] TEMP_RECIP = 17'd83887;
    localparam int unsigned TempShift  = 23;

    // bytes 1..9 of a gathered frame, words already assembled little-endian
    typedef struct packed {
        logic [7:0]  frame_type;
        logic [15:0] word_x;
        logic [15:0] word_y;
        logic [15:0] word_z;
        logic [15:0] word_temp;
    } t_frame;

    typedef struct packed {
        logic load;   // final byte taken, result register may load
        logic drain;  // downstream takes the held result this cycle
    } t_dec_ctrl;

endpackage

### rtl/imu_serial_frame_parser.sv
// IMU serial frame parser: 11-byte 0x55-headed frames to axis/temperature results.
// Results are registered: o_valid rises in the cycle after a known-type frame's final byte is accepted.
// Throughput: one byte per cycle; only the final byte of a frame waits, and only
// while the result register is full and stalled downstream.
// Reset (synchronous, active low) clears the byte counter and the result valid;
// the frame byte store is not cleared.
module imu_serial_frame_parser
    import imu_sfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic        [7:0]  i_rx_byte,
    output logic               o_valid,
    input  logic               i_stall,
    output logic        [1:0]  o_frame_kind,
    output logic signed [15:0] o_axis_x,
    output logic signed [15:0] o_axis_y,
    output logic signed [15:0] o_axis_z,
    output logic        [9:0]  o_temperature
);

    logic      take;
    logic      last;
    t_frame    frame;
    t_dec_ctrl ctrl;

    // final byte needs a free result slot
    assign o_stall    = last && o_valid && i_stall;
    assign take       = i_valid && !o_stall;
    assign ctrl.load  = take && last;
    assign ctrl.drain = o_valid && !i_stall;

    imu_sfp_assembler u_asm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_byte  (i_rx_byte),
        .o_last  (last),
        .o_frame (frame)
    );

    imu_sfp_decode u_dec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_frame       (frame),
        .o_valid       (o_valid),
        .o_frame_kind  (o_frame_kind),
        .o_axis_x      (o_axis_x),
        .o_axis_y      (o_axis_y),
        .o_axis_z      (o_axis_z),
        .o_temperature (o_temperature)
    );

    a_stall_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> last && o_valid)
        else $error("input stalled outside frame end");

endmodule

### rtl/imu_sfp_assembler.sv
// Header hunt, byte counter and frame byte store.
// Depends on imu_sfp_pkg.
module imu_sfp_assembler
    import imu_sfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_byte,
    output logic       o_last,
    output t_frame     o_frame
);

    logic [CountW-1:0] r_count;
    logic [CountW-1:0] n_count;
    logic [7:0]        r_bytes [StoredLen];
    logic              in_frame;
    logic              at_last;

    // out-of-range count behaves as zero
    assign in_frame = (r_count != '0) && (r_count < CountW'(StoredLen + 1));
    assign at_last  = (r_count == CountW'(StoredLen));
    assign o_last   = at_last;

    always_comb begin
        n_count = r_count;
        if (i_take) begin
            if (!in_frame) begin
                n_count = (i_byte == HDR_BYTE) ? CountW'(1) : '0;
            end else if (at_last) begin
                n_count = '0;
            end else begin
                n_count = r_count + CountW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && in_frame && !at_last) begin
            r_bytes[r_count] <= i_byte;
        end
    end

    assign o_frame.frame_type = r_bytes[1];
    assign o_frame.word_x     = {r_bytes[3], r_bytes[2]};
    assign o_frame.word_y     = {r_bytes[5], r_bytes[4]};
    assign o_frame.word_z     = {r_bytes[7], r_bytes[6]};
    assign o_frame.word_temp  = {r_bytes[9], r_bytes[8]};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CountW'(StoredLen))
        else $error("byte count out of range");

    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_take && at_last |=> r_count == '0)
        else $error("parser did not restart after frame");

endmodule

### rtl/imu_sfp_decode.sv
// Frame type decode, temperature scaling and the result register.
// Depends on imu_sfp_pkg.
module imu_sfp_decode
    import imu_sfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dec_ctrl          i_ctrl,
    input  t_frame             i_frame,
    output logic               o_valid,
    output logic        [1:0]  o_frame_kind,
    output logic signed [15:0] o_axis_x,
    output logic signed [15:0] o_axis_y,
    output logic signed [15:0] o_axis_z,
    output logic        [9:0]  o_temperature
);

    logic        r_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic [15:0] r_z;
    logic [9:0]  r_temp;
    logic        known;
    logic [7:0]  kind_full;
    logic [32:0] temp_prod;

    assign known     = (i_frame.frame_type >= TYPE_ACCEL) && (i_frame.frame_type <= TYPE_MAG);
    assign kind_full = i_frame.frame_type - TYPE_ACCEL;
    assign temp_prod = {17'd0, i_frame.word_temp} * {16'd0, TEMP_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.load && known) begin
            r_valid <= 1'b1;
        end else if (i_ctrl.drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && known) begin
            r_kind <= kind_full[1:0];
            r_x    <= i_frame.word_x;
            r_y    <= i_frame.word_y;
            r_z    <= i_frame.word_z;
            r_temp <= temp_prod[TempShift +: 10];
        end
    end

    assign o_valid       = r_valid;
    assign o_frame_kind  = r_kind;
    assign o_axis_x      = signed'(r_x);
    assign o_axis_y      = signed'(r_y);
    assign o_axis_z      = signed'(r_z);
    assign o_temperature = r_temp;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !i_ctrl.drain |-> !i_ctrl.load)
        else $error("result register overwritten while held");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load && known |=> r_valid)
        else $error("known frame produced no result");

endmodule
